>>> hdl/prl_pkg.sv
// ----------------------------------------------------------------------------
// prl_pkg: shared types and constants of the per-client rate limiter
// Request/result payloads, configuration set, controller commands and
// status, outcome codes and register reset values.
// ----------------------------------------------------------------------------
package prl_pkg;

  localparam int KEY_W  = 32;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 16;
  localparam int SLOT_W = 6;
  localparam int OUT_W  = 2;

  // APB port geometry: two registers, 16 bits in 32-bit words, at byte offsets 0 and 4
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int REG_SEL_BIT = 2;

  // register select codes (value of the address select bit)
  localparam logic REG_LIMIT  = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  localparam logic [CNT_W-1:0] RESET_LIMIT  = 16'd60;
  localparam logic [CNT_W-1:0] RESET_WINDOW = 16'd60;

  // outcome codes
  localparam logic [OUT_W-1:0] OUT_COUNTED = 2'd0;
  localparam logic [OUT_W-1:0] OUT_RESTART = 2'd1;
  localparam logic [OUT_W-1:0] OUT_DENIED  = 2'd2;
  localparam logic [OUT_W-1:0] OUT_NEW     = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]  client_key;
    logic [TIME_W-1:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic              allowed;
    logic [SLOT_W-1:0] slot;
    logic [OUT_W-1:0]  outcome;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] request_limit;
    logic [CNT_W-1:0] window_seconds;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the request
    logic match;   // capture lookup result, arm the eviction scan
    logic scan;    // examine one entry for eviction
    logic update;  // apply hit decision and emit result
    logic evict;   // take over victim entry and emit result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_last;
  } sts_t;

endpackage

>>> hdl/per_client_rate_limiter.sv
// Sequence: a known client passes lookup and the hit update; a new client
// passes lookup, the eviction scan (one entry/cycle) and the victim takeover.
// The block takes no new request while busy; busy drops with the strobe, and
// the eviction scan walks the entries through the single table read port.
// Reset: all entries invalid at once, request_limit and window_seconds = 60.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
// per_client_rate_limiter: fixed-window request limiter per client
// Top level joining the configuration registers, the sequencer and the
// client table datapath.
// ----------------------------------------------------------------------------
module per_client_rate_limiter #(
  parameter int ENTRIES = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  prl_pkg::req_t               req_i,
  output logic                        done_o,
  output prl_pkg::res_t               res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prl_pkg::APB_AW-1:0]  paddr,
  input  logic [prl_pkg::APB_DW-1:0]  pwdata,
  output logic [prl_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import prl_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  prl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  prl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  prl_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .cfg_i  (cfg),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

`ifndef SYNTH
  // a result shows only once the sequencer is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // every request completion drops busy together with the strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy) |-> done_o)
    else $error("busy fell without a result");

  // one strobe per request
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // an accepted request keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("request accepted but block not busy");
`endif

endmodule

>>> hdl/prl_regs.sv
// ----------------------------------------------------------------------------
// prl_regs: configuration registers
// APB slave holding request_limit (offset 0) and window_seconds (offset 4).
// ----------------------------------------------------------------------------
module prl_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [prl_pkg::APB_AW-1:0]   paddr,
  input  logic [prl_pkg::APB_DW-1:0]   pwdata,
  output logic [prl_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output prl_pkg::cfg_t                cfg_o
);
  import prl_pkg::*;

  logic [CNT_W-1:0] limit_q, limit_d;
  logic [CNT_W-1:0] window_q, window_d;
  logic             wr_en;
  logic             sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign sel    = paddr[REG_SEL_BIT];

  // decode a write transfer
  always_comb begin
    limit_d  = limit_q;
    window_d = window_q;
    if (wr_en) begin
      unique case (sel)
        REG_LIMIT:  limit_d  = pwdata[CNT_W-1:0];
        REG_WINDOW: window_d = pwdata[CNT_W-1:0];
        default:    limit_d  = limit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= RESET_LIMIT;
      window_q <= RESET_WINDOW;
    end else begin
      limit_q  <= limit_d;
      window_q <= window_d;
    end
  end

  // read back the selected register
  always_comb begin
    unique case (sel)
      REG_LIMIT:  prdata = {{(APB_DW-CNT_W){1'b0}}, limit_q};
      REG_WINDOW: prdata = {{(APB_DW-CNT_W){1'b0}}, window_q};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.request_limit  = limit_q;
  assign cfg_o.window_seconds = window_q;

endmodule

>>> hdl/prl_ctrl.sv
// ----------------------------------------------------------------------------
// prl_ctrl: request sequencer
// Walks each request through lookup, then either the hit update or the
// eviction scan and takeover.
// ----------------------------------------------------------------------------
module prl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  prl_pkg::sts_t sts_i,
  output prl_pkg::cmd_t cmd_o
);
  import prl_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MATCH  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_EVICT  = 3'd4;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = sts_i.hit ? S_UPDATE : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_EVICT;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_IDLE;
      end
      S_EVICT: begin
        cmd_o.evict = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

>>> hdl/prl_dp.sv
// ----------------------------------------------------------------------------
// prl_dp: client table and decision datapath
// Holds the entry table, matches the request key against all entries in
// parallel, scans one entry per cycle for the oldest window on a miss,
// and registers the result.
// ----------------------------------------------------------------------------
module prl_dp #(
  parameter int ENTRIES = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  prl_pkg::cmd_t cmd_i,
  output prl_pkg::sts_t sts_o,
  input  prl_pkg::cfg_t cfg_i,
  input  prl_pkg::req_t req_i,
  output logic          done_o,
  output prl_pkg::res_t res_o
);
  import prl_pkg::*;

  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // entry table
  logic [ENTRIES-1:0] valid_q;
  logic [KEY_W-1:0]   key_q   [ENTRIES];
  logic [CNT_W-1:0]   count_q [ENTRIES];
  logic [TIME_W-1:0]  start_q [ENTRIES];

  // request and sequencing registers
  req_t              req_q;
  logic [IdxW-1:0]   hit_idx_q;
  logic [IdxW-1:0]   scan_idx_q;
  logic [IdxW-1:0]   victim_q;
  logic [TIME_W-1:0] vstart_q;
  res_t              res_q, res_d;
  logic              done_q;

  logic [ENTRIES-1:0] match;
  logic               hit;
  logic [IdxW-1:0]    hit_idx;
  logic [IdxW-1:0]    rd_idx;
  logic [TIME_W-1:0]  start_rd;
  logic [TIME_W-1:0]  start_eff;
  logic [CNT_W-1:0]   count_rd;
  logic [TIME_W-1:0]  elapsed;
  logic               expired;
  logic               at_limit;
  logic               take;

  // compare the key against every entry, keep the lowest match
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (key_q[i] == req_q.client_key);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IdxW'(i);
      end
    end
  end
  assign hit = |match;

  // single read port: scan pointer while scanning, else the hit entry
  assign rd_idx    = cmd_i.scan ? scan_idx_q : hit_idx_q;
  assign start_rd  = start_q[rd_idx];
  assign count_rd  = count_q[rd_idx];
  assign start_eff = valid_q[rd_idx] ? start_rd : '0;

  // window and limit checks for the hit entry
  assign elapsed  = req_q.now_seconds - start_rd;
  assign expired  = elapsed >= {{(TIME_W-CNT_W){1'b0}}, cfg_i.window_seconds};
  assign at_limit = count_rd >= cfg_i.request_limit;

  // eviction scan: first entry always taken, then strictly older ones
  assign take = (scan_idx_q == '0) || (start_eff < vstart_q);

  assign sts_o.hit       = hit;
  assign sts_o.scan_last = (scan_idx_q == IdxW'(ENTRIES - 1));

  // capture request and lookup, advance the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.match) begin
      hit_idx_q  <= hit_idx;
      scan_idx_q <= '0;
    end
    if (cmd_i.scan) begin
      if (take) begin
        victim_q <= scan_idx_q;
        vstart_q <= start_eff;
      end
      if (!sts_o.scan_last) begin
        scan_idx_q <= scan_idx_q + IdxW'(1);
      end
    end
  end

  // write back the table
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && expired) begin
      count_q[hit_idx_q] <= CNT_W'(1);
      start_q[hit_idx_q] <= req_q.now_seconds;
    end else if (cmd_i.update && !at_limit) begin
      count_q[hit_idx_q] <= count_rd + CNT_W'(1);
    end
    if (cmd_i.evict) begin
      key_q[victim_q]   <= req_q.client_key;
      count_q[victim_q] <= CNT_W'(1);
      start_q[victim_q] <= req_q.now_seconds;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.evict) begin
      valid_q[victim_q] <= 1'b1;
    end
  end

  // form the result
  always_comb begin
    res_d = res_q;
    if (cmd_i.update) begin
      res_d.slot = SLOT_W'(hit_idx_q);
      priority if (expired) begin
        res_d.allowed = 1'b1;
        res_d.outcome = OUT_RESTART;
      end else if (at_limit) begin
        res_d.allowed = 1'b0;
        res_d.outcome = OUT_DENIED;
      end else begin
        res_d.allowed = 1'b1;
        res_d.outcome = OUT_COUNTED;
      end
    end else if (cmd_i.evict) begin
      res_d.allowed = 1'b1;
      res_d.slot    = SLOT_W'(victim_q);
      res_d.outcome = OUT_NEW;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // strobe the result for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.update | cmd_i.evict;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
